[rtl/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/tcw_pkg.sv]
package tcw_pkg;

    // address arithmetic: row (6b) * columns (7b) + column (7b)
    localparam int CALC_W      = 14;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 6;
    localparam int CHAR_W      = 8;
    localparam int RADDR_W     = 11;
    localparam int KIND_W      = 3;
    localparam int OUT_COL_W   = 6;
    localparam int OUT_ROW_W   = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    localparam logic [CHAR_W-1:0] GLYPH_CURSOR = 8'd248;
    localparam logic [CHAR_W-1:0] GLYPH_SPACE  = 8'd32;
    localparam logic [CHAR_W-1:0] CODE_CR      = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_LF      = 8'd10;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS    = 2'd1;

    localparam logic [COL_W-1:0] RESET_COLUMNS = 7'd32;
    localparam logic [ROW_W-1:0] RESET_ROWS    = 6'd24;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT          = 3'd0,
        KIND_DRAW_CURSOR  = 3'd1,
        KIND_ERASE_CURSOR = 3'd2,
        KIND_CLEAR        = 3'd3,
        KIND_READ         = 3'd4
    } kind_t;

    typedef struct packed {
        logic [COL_W-1:0] cols;
        logic [ROW_W-1:0] rows;
    } geom_t;

    typedef struct packed {
        kind_t              kind;
        logic [CHAR_W-1:0]  char_code;
        logic [RADDR_W-1:0] read_address;
    } item_t;

    typedef struct packed {
        logic              we;
        logic [CALC_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [CALC_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic                 valid;
        logic [CHAR_W-1:0]    read_char;
        logic [OUT_COL_W-1:0] column;
        logic [OUT_ROW_W-1:0] row;
    } result_t;

endpackage

[rtl/tcw_char_mem.sv]
module tcw_char_mem
    import tcw_pkg::*;
#(
    parameter int CELL_COUNT = 2048
) (
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [CHAR_W-1:0] rdata
);

    localparam int AW = $clog2(CELL_COUNT);

    logic [CHAR_W-1:0] mem [CELL_COUNT];
    logic [CHAR_W-1:0] rdata_reg;

    // caller keeps both addresses below CELL_COUNT
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tcw_ctrl.sv]
`include "assert_macros.svh"

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int CELL_COUNT = 2048
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  geom_t             geom,
    input  logic              in_valid,
    output logic              in_ready,
    input  item_t             item,
    input  logic              res_ready,
    output result_t           res,
    output mem_req_t          mem_req,
    input  logic [CHAR_W-1:0] mem_rdata
);

    localparam logic [CALC_W-1:0] CELLS = CALC_W'(CELL_COUNT);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [COL_W-1:0]  wcol_reg, wcol_next;
    logic [ROW_W-1:0]  wrow_reg, wrow_next;
    logic [COL_W-1:0]  ccol_reg, ccol_next;
    logic [ROW_W-1:0]  crow_reg, crow_next;
    logic [CALC_W-1:0] idx_reg, idx_next;
    logic [CALC_W-1:0] end_reg, end_next;
    logic              pend_reg, pend_next;
    logic              pend_oor_reg, pend_oor_next;
    logic [CALC_W-1:0] pend_addr_reg, pend_addr_next;
    logic [CHAR_W-1:0] rd_reg, rd_next;
    logic [CALC_W-1:0] area_reg, area_next;

    logic [COL_W-1:0]  pos_col;
    logic [ROW_W-1:0]  pos_row;
    logic [CALC_W-1:0] pos_row_x, cols_x, pos_addr, src_addr, scroll_size;
    logic              pos_ok;
    logic [COL_W-1:0]  col_inc;
    logic [ROW_W-1:0]  row_inc;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic              put_write;

    // erase uses the cursor position, the other kinds the write position
    always_comb begin
        pos_col   = (item_reg.kind == KIND_ERASE_CURSOR) ? ccol_reg : wcol_reg;
        pos_row   = (item_reg.kind == KIND_ERASE_CURSOR) ? crow_reg : wrow_reg;
        pos_row_x = CALC_W'(pos_row);
        cols_x    = CALC_W'(geom.cols);
        pos_addr  = pos_row_x * cols_x + CALC_W'(pos_col);
        pos_ok    = pos_addr < CELLS;
        area_next = CALC_W'(geom.rows) * cols_x;
        scroll_size = area_reg - cols_x;
        src_addr  = idx_reg + cols_x;
        col_inc   = wcol_reg + 1'b1;
        row_inc   = wrow_reg + 1'b1;
    end

    always_comb begin
        put_write = 1'b0;
        put_col   = wcol_reg;
        put_row   = wrow_reg;
        if (item_reg.char_code == CODE_CR) begin
            put_col = '0;
        end else if (item_reg.char_code == CODE_LF) begin
            put_row = row_inc;
        end else begin
            put_write = 1'b1;
            if (col_inc >= geom.cols) begin
                put_col = '0;
                put_row = row_inc;
            end else begin
                put_col = col_inc;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        wcol_next      = wcol_reg;
        wrow_next      = wrow_reg;
        ccol_next      = ccol_reg;
        crow_next      = crow_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        pend_next      = 1'b0;
        pend_oor_next  = pend_oor_reg;
        pend_addr_next = pend_addr_reg;
        rd_next        = rd_reg;
        in_ready       = 1'b0;
        res            = '0;
        mem_req        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next  = item;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                rd_next    = '0;
                state_next = ST_DONE;
                unique case (item_reg.kind)
                    KIND_PUT: begin
                        mem_req.we    = put_write && pos_ok;
                        mem_req.waddr = pos_addr;
                        mem_req.wdata = item_reg.char_code;
                        wcol_next     = put_col;
                        wrow_next     = put_row;
                        if (put_row >= geom.rows) begin
                            // scroll: copy rows up, then blank the bottom row
                            idx_next   = '0;
                            end_next   = scroll_size;
                            state_next = ST_COPY;
                        end
                    end
                    KIND_DRAW_CURSOR: begin
                        mem_req.we    = pos_ok;
                        mem_req.waddr = pos_addr;
                        mem_req.wdata = GLYPH_CURSOR;
                        if (wcol_reg >= geom.cols) begin
                            ccol_next = '0;
                            crow_next = row_inc;
                        end else begin
                            ccol_next = wcol_reg;
                            crow_next = wrow_reg;
                        end
                    end
                    KIND_ERASE_CURSOR: begin
                        mem_req.we    = pos_ok;
                        mem_req.waddr = pos_addr;
                        mem_req.wdata = GLYPH_SPACE;
                    end
                    KIND_CLEAR: begin
                        idx_next   = '0;
                        end_next   = area_reg;
                        state_next = ST_CLEAR;
                    end
                    KIND_READ: begin
                        mem_req.re    = CALC_W'(item_reg.read_address) < CELLS;
                        mem_req.raddr = CALC_W'(item_reg.read_address);
                        state_next    = ST_READ;
                    end
                    default: ;
                endcase
                // short kinds hand the result over right away when there is room
                if (state_next == ST_DONE && res_ready) begin
                    res.valid  = 1'b1;
                    res.column = wcol_next[OUT_COL_W-1:0];
                    res.row    = wrow_next[OUT_ROW_W-1:0];
                    state_next = ST_IDLE;
                end
            end

            ST_READ: begin
                if (CALC_W'(item_reg.read_address) < CELLS) begin
                    rd_next = mem_rdata;
                end else begin
                    rd_next = '0;
                end
                state_next = ST_DONE;
            end

            ST_COPY: begin
                // write of the cell read last cycle; source is always ahead
                mem_req.we    = pend_reg && !(pend_addr_reg >= CELLS);
                mem_req.waddr = pend_addr_reg;
                mem_req.wdata = pend_oor_reg ? '0 : mem_rdata;
                if (idx_reg < end_reg) begin
                    mem_req.re     = src_addr < CELLS;
                    mem_req.raddr  = src_addr;
                    pend_next      = 1'b1;
                    pend_oor_next  = !(src_addr < CELLS);
                    pend_addr_next = idx_reg;
                    idx_next       = idx_reg + 1'b1;
                end else begin
                    end_next   = area_reg;
                    state_next = ST_FILL;
                end
            end

            ST_FILL: begin
                if (idx_reg < end_reg) begin
                    mem_req.we    = idx_reg < CELLS;
                    mem_req.waddr = idx_reg;
                    mem_req.wdata = GLYPH_SPACE;
                    idx_next      = idx_reg + 1'b1;
                end else begin
                    wrow_next  = geom.rows - 1'b1;
                    wcol_next  = '0;
                    state_next = ST_DONE;
                end
            end

            ST_INIT, ST_CLEAR: begin
                if (idx_reg < end_reg) begin
                    mem_req.we    = idx_reg < CELLS;
                    mem_req.waddr = idx_reg;
                    mem_req.wdata = GLYPH_SPACE;
                    idx_next      = idx_reg + 1'b1;
                end else begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end

            ST_DONE: begin
                if (res_ready) begin
                    res.valid     = 1'b1;
                    res.read_char = rd_reg;
                    res.column    = wcol_reg[OUT_COL_W-1:0];
                    res.row       = wrow_reg[OUT_ROW_W-1:0];
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            wcol_reg  <= '0;
            wrow_reg  <= '0;
            ccol_reg  <= '0;
            crow_reg  <= '0;
            idx_reg   <= '0;
            end_reg   <= CELLS;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            wcol_reg  <= wcol_next;
            wrow_reg  <= wrow_next;
            ccol_reg  <= ccol_next;
            crow_reg  <= crow_next;
            idx_reg   <= idx_next;
            end_reg   <= end_next;
            pend_reg  <= pend_next;
        end
        item_reg      <= item_next;
        pend_oor_reg  <= pend_oor_next;
        pend_addr_reg <= pend_addr_next;
        rd_reg        <= rd_next;
        area_reg      <= area_next;
    end

    `TCW_ASSERT_IMPL(a_res_needs_room, aclk, aresetn, res.valid, res_ready, "result issued with output register full")
    `TCW_ASSERT_IMPL(a_copy_no_collision, aclk, aresetn, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "scroll read and write hit the same cell")
    `TCW_ASSERT_IMPL(a_walk_quiet, aclk, aresetn, (state_reg == ST_INIT) || (state_reg == ST_CLEAR) || (state_reg == ST_COPY) || (state_reg == ST_FILL), !res.valid && !in_ready, "item or result during memory walk")
    `TCW_ASSERT_NEXT(a_one_item, aclk, aresetn, in_valid && in_ready, !in_ready, "second item taken while one is in flight")

endmodule

[rtl/text_console_writer_core.sv]
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tuser: kind; tdata: char_code, read_address
// m_       out  m_tvalid/m_tready  tdata: read_char, column, row
// cfg_     in   cfg_we             cfg_index selects register, cfg_wdata value
//
// Put character, return, line feed, draw and erase cursor: one item at a time, run in the exec state.
// Read cell: the read is issued in the exec state and the byte registered in the read state.
// Scroll: rows*columns cells, one cell per cycle through the memory port.
// Clear screen: rows*columns cells, one cell per cycle.
// After reset a clearing pass writes spaces to all CELL_COUNT cells with s_tready low;
// config writes are taken meanwhile.
// A stalled m_ side holds the result in the output register; one more item is
// accepted meanwhile and waits for it to drain.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 32,
    parameter int CELL_COUNT  = 2048
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] char_code, [18:8] read_address
    input  logic [KIND_W-1:0]      s_tuser,   // [2:0] kind
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [7:0] read_char, [13:8] column, [18:14] row
    // register writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // configuration registers, raw as written
    logic [COL_W-1:0] cols_cfg_reg;
    logic [ROW_W-1:0] rows_cfg_reg;
    geom_t            geom;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= RESET_COLUMNS;
            rows_cfg_reg <= RESET_ROWS;
        end else if (cfg_we) begin
            // indexes past the list are dropped
            if (cfg_index == REG_SCREEN_COLUMNS) begin
                cols_cfg_reg <= cfg_wdata;
            end else if (cfg_index == REG_SCREEN_ROWS) begin
                rows_cfg_reg <= cfg_wdata[ROW_W-1:0];
            end
        end
    end

    // effective geometry: zero reads as one, clamp at the maxima
    always_comb begin
        priority if (cols_cfg_reg == '0) begin
            geom.cols = COL_W'(1);
        end else if (int'(cols_cfg_reg) > MAX_COLUMNS) begin
            geom.cols = COL_W'(MAX_COLUMNS);
        end else begin
            geom.cols = cols_cfg_reg;
        end
        priority if (rows_cfg_reg == '0) begin
            geom.rows = ROW_W'(1);
        end else if (int'(rows_cfg_reg) > MAX_ROWS) begin
            geom.rows = ROW_W'(MAX_ROWS);
        end else begin
            geom.rows = rows_cfg_reg;
        end
    end

    item_t             item;
    result_t           res;
    mem_req_t          mem_req;
    logic [CHAR_W-1:0] mem_rdata;
    logic              res_ready;

    assign item.kind         = kind_t'(s_tuser);
    assign item.char_code    = s_tdata[CHAR_W-1:0];
    assign item.read_address = s_tdata[CHAR_W +: RADDR_W];

    tcw_ctrl #(
        .CELL_COUNT (CELL_COUNT)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geom      (geom),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    tcw_char_mem #(
        .CELL_COUNT (CELL_COUNT)
    ) u_char_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // output register: parts the core from a stalled consumer
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign res_ready     = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = res.valid || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (res.valid) begin
            m_tdata_reg <= M_TDATA_W'({res.row, res.column, res.read_char});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
